// ----- src/lpfp_pkg.sv -----
// ----------------------------------------------------------------------------
// lpfp_pkg
// Shared types and constants for the lidar packet framer and parser.
// ----------------------------------------------------------------------------
package lpfp_pkg;

	localparam logic [7:0]  HDR0    = 8'hAA;
	localparam logic [7:0]  HDR1    = 8'h55;
	localparam logic [15:0] CS_INIT = 16'h55AA;

	// frame phase
	localparam logic [1:0] PH_HUNT = 2'd0;
	localparam logic [1:0] PH_SYNC = 2'd1;
	localparam logic [1:0] PH_BODY = 2'd2;

	// byte positions inside a packet (header is 0 and 1)
	localparam logic [9:0] POS_CT    = 10'd2;
	localparam logic [9:0] POS_LSN   = 10'd3;
	localparam logic [9:0] POS_FSA_L = 10'd4;
	localparam logic [9:0] POS_FSA_H = 10'd5;
	localparam logic [9:0] POS_LSA_L = 10'd6;
	localparam logic [9:0] POS_LSA_H = 10'd7;
	localparam logic [9:0] POS_CS_L  = 10'd8;
	localparam logic [9:0] POS_CS_H  = 10'd9;

	// result status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_CSUM = 2'd1;
	localparam logic [1:0] ST_OVER = 2'd2;

	localparam int          ANGLE_BINS   = 360;
	localparam logic [15:0] FULL_TURN    = 16'd23040;
	localparam logic [4:0]  DIV_STEPS    = 5'd15;
	localparam logic [4:0]  CORDIC_STEPS = 5'd17;

	typedef struct packed {
		logic byte_en;
		logic pend_clr;
		logic div_start;
		logic div_step;
		logic idx_inc;
		logic rd_en;
		logic cor_load;
		logic cor_step;
		logic ang_calc;
		logic pend_load;
		logic push_pend;
		logic push_final;
	} lpfp_cmd_t;

	typedef struct packed {
		logic fin;
		logic abort;
		logic idx_done;
		logic dzero;
		logic div_done;
		logic cor_done;
		logic have_pend;
		logic out_free;
	} lpfp_sts_t;

	// atan(2^-i) in 1/16384 degree
	function automatic logic [19:0] atan_lut(input logic [4:0] i);
		logic [19:0] v;
		case (i)
			5'd0:    v = 20'd737280;
			5'd1:    v = 20'd435242;
			5'd2:    v = 20'd229970;
			5'd3:    v = 20'd116736;
			5'd4:    v = 20'd58595;
			5'd5:    v = 20'd29326;
			5'd6:    v = 20'd14667;
			5'd7:    v = 20'd7334;
			5'd8:    v = 20'd3667;
			5'd9:    v = 20'd1833;
			5'd10:   v = 20'd917;
			5'd11:   v = 20'd458;
			5'd12:   v = 20'd229;
			5'd13:   v = 20'd115;
			5'd14:   v = 20'd57;
			5'd15:   v = 20'd29;
			5'd16:   v = 20'd14;
			default: v = 20'd0;
		endcase
		return v;
	endfunction

endpackage

// ----- src/lpfp_ram.sv -----
// ----------------------------------------------------------------------------
// lpfp_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lpfp_ram #(
	parameter int WIDTH = 14,
	parameter int DEPTH = 64
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- src/lpfp_datapath.sv -----
// ----------------------------------------------------------------------------
// lpfp_datapath
// Byte framing, checksum, sample store, interpolation divider, CORDIC
// angle correction and the output register.
// ----------------------------------------------------------------------------
module lpfp_datapath
	import lpfp_pkg::*;
#(
	parameter int MAX_SAMPLES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  lpfp_cmd_t   cmd,
	output lpfp_sts_t   sts,
	input  logic [7:0]  rx_byte,
	input  logic        out_ready,
	output logic        out_valid,
	output logic [1:0]  status,
	output logic        has_sample,
	output logic [8:0]  angle_bin,
	output logic [13:0] distance_mm,
	output logic        last
);

	localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
	localparam logic signed [17:0] TURN_X3 = 18'sd69120;

	// framing state
	logic [1:0]  phase_q;
	logic [9:0]  pos_q;
	logic [7:0]  lsn_q;
	logic [15:0] fsa_w_q, lsa_w_q, rxcs_q, cs_q;
	logic [7:0]  part_q;
	logic [1:0]  j_q;
	logic [7:0]  sidx_q;
	logic        fin_q;

	logic [9:0]  end_pos;
	logic        is_end;
	logic        ram_we;
	logic [13:0] ram_rdata;

	assign end_pos = 10'd9 + {2'b0, lsn_q} + {1'b0, lsn_q, 1'b0};
	assign is_end  = (phase_q == PH_BODY) && (pos_q >= POS_CS_H) && (pos_q == end_pos);
	assign ram_we  = cmd.byte_en && (phase_q == PH_BODY) && (pos_q > POS_CS_H)
		&& (j_q == 2'd2) && ({1'b0, sidx_q} < 9'(MAX_SAMPLES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			pos_q   <= '0;
			cs_q    <= CS_INIT;
			j_q     <= '0;
			sidx_q  <= '0;
			fin_q   <= 1'b0;
		end else if (cmd.byte_en) begin
			fin_q <= is_end;
			case (phase_q)
				PH_HUNT: begin
					if (rx_byte == HDR0) phase_q <= PH_SYNC;
				end
				PH_SYNC: begin
					if (rx_byte == HDR1) begin
						phase_q <= PH_BODY;
						pos_q   <= POS_CT;
						cs_q    <= CS_INIT;
						j_q     <= '0;
						sidx_q  <= '0;
					end else if (rx_byte != HDR0) begin
						phase_q <= PH_HUNT;
					end
				end
				default: begin
					case (pos_q)
						POS_CT:    cs_q <= cs_q ^ {8'h00, rx_byte};
						POS_LSN:   cs_q <= cs_q ^ {rx_byte, 8'h00};
						POS_FSA_L: cs_q <= cs_q ^ {8'h00, rx_byte};
						POS_FSA_H: cs_q <= cs_q ^ {rx_byte, 8'h00};
						POS_LSA_L: cs_q <= cs_q ^ {8'h00, rx_byte};
						POS_LSA_H: cs_q <= cs_q ^ {rx_byte, 8'h00};
						POS_CS_L:  ;
						POS_CS_H:  ;
						default: begin
							if (j_q == 2'd2) begin
								cs_q   <= cs_q ^ {rx_byte, 8'h00};
								j_q    <= '0;
								sidx_q <= sidx_q + 8'd1;
							end else begin
								cs_q <= cs_q ^ {8'h00, rx_byte};
								j_q  <= j_q + 2'd1;
							end
						end
					endcase
					if (is_end) begin
						phase_q <= PH_HUNT;
						pos_q   <= '0;
					end else begin
						pos_q <= pos_q + 10'd1;
					end
				end
			endcase
		end
	end

	// header fields, payload only
	always_ff @(posedge clk) begin
		if (cmd.byte_en && phase_q == PH_BODY) begin
			case (pos_q)
				POS_LSN:   lsn_q   <= rx_byte;
				POS_FSA_L: fsa_w_q <= {8'h00, rx_byte};
				POS_FSA_H: fsa_w_q <= {rx_byte, fsa_w_q[7:0]};
				POS_LSA_L: lsa_w_q <= {8'h00, rx_byte};
				POS_LSA_H: lsa_w_q <= {rx_byte, lsa_w_q[7:0]};
				POS_CS_L:  rxcs_q  <= {8'h00, rx_byte};
				POS_CS_H:  rxcs_q  <= {rx_byte, rxcs_q[7:0]};
				default: begin
					if (j_q == 2'd1) part_q <= rx_byte;
				end
			endcase
		end
	end

	// emission index and interpolation
	logic [7:0]  i_q;
	logic [14:0] q_q, dq_q;
	logic [7:0]  r_q, rem_q;
	logic [4:0]  step_q;
	logic [7:0]  div_l;
	logic        multi;
	logic [14:0] fsa, lsa;
	logic [15:0] diff_raw, diff, diff_mag;
	logic        diff_neg;
	logic [8:0]  div_t, rsum;

	assign fsa      = fsa_w_q[15:1];
	assign lsa      = lsa_w_q[15:1];
	assign diff_raw = {1'b0, lsa} - {1'b0, fsa};
	assign diff     = diff_raw[15] ? diff_raw + FULL_TURN : diff_raw;
	// start word beyond a full turn can leave the span negative: step downwards,
	// truncating toward zero
	assign diff_neg = diff[15];
	assign diff_mag = diff_neg ? 16'd0 - diff : diff;
	assign div_l    = lsn_q - 8'd1;
	assign multi    = lsn_q > 8'd1;
	assign div_t    = {rem_q, dq_q[14]};
	assign rsum     = {1'b0, r_q} + {1'b0, rem_q};

	lpfp_ram #(
		.WIDTH(14),
		.DEPTH(MAX_SAMPLES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(sidx_q[AW-1:0]),
		.wdata({rx_byte[7:0], part_q[7:2]}),
		.re   (cmd.rd_en),
		.raddr(i_q[AW-1:0]),
		.rdata(ram_rdata)
	);

	// CORDIC
	function automatic logic [27:0] d_in_mul(input logic [13:0] d);
		return 28'(d) * 28'd15530;
	endfunction

	logic signed [47:0] x_q, y_q, xs, ys;
	logic signed [23:0] z_q, z_r;
	logic [13:0]        d_q;
	logic [27:0]        xm;
	logic signed [18:0] yt;
	logic signed [26:0] yt27, ym;
	logic [17:0]        d10;

	assign xm   = 28'(d_in_mul(ram_rdata));
	assign d10  = 18'({4'b0, ram_rdata}) * 18'd10;
	assign yt   = 19'sd1553 - $signed({1'b0, d10});
	assign yt27 = 27'(yt);
	assign ym   = yt27 * 27'sd218;
	assign xs   = x_q >>> step_q;
	assign ys   = y_q >>> step_q;
	assign z_r  = z_q + 24'sd128;

	// final angle
	logic signed [15:0] corr;
	logic signed [17:0] q_s, s_ang, s_wrap;
	logic [14:0]        w_ang;
	logic [15:0]        b_sum;
	logic [8:0]         bin;
	logic [8:0]         cand_bin_q, pend_bin_q;
	logic [13:0]        pend_d_q;
	logic               have_pend_q;

	always_comb begin
		corr  = z_r[23:8];
		q_s   = diff_neg ? -$signed({3'b0, q_q}) : $signed({3'b0, q_q});
		s_ang = $signed({3'b0, fsa}) + q_s + 18'(corr);
		if (s_ang < 0) begin
			s_wrap = s_ang + $signed({2'b0, FULL_TURN});
		end else if (s_ang >= TURN_X3) begin
			s_wrap = s_ang - TURN_X3;
		end else if (s_ang >= $signed({1'b0, FULL_TURN, 1'b0})) begin
			s_wrap = s_ang - $signed({1'b0, FULL_TURN, 1'b0});
		end else if (s_ang >= $signed({2'b0, FULL_TURN})) begin
			s_wrap = s_ang - $signed({2'b0, FULL_TURN});
		end else begin
			s_wrap = s_ang;
		end
		w_ang = s_wrap[14:0];
		b_sum = {1'b0, w_ang} + 16'd32;
		bin   = b_sum[14:6];
		if (bin == 9'(ANGLE_BINS)) bin = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			have_pend_q <= 1'b0;
			i_q         <= '0;
		end else begin
			if (cmd.div_start || cmd.cor_load) step_q <= '0;
			else if (cmd.div_step || cmd.cor_step) step_q <= step_q + 5'd1;
			if (cmd.pend_clr) begin
				have_pend_q <= 1'b0;
				i_q         <= '0;
			end else begin
				if (cmd.pend_load) have_pend_q <= 1'b1;
				if (cmd.idx_inc) i_q <= i_q + 8'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pend_clr) begin
			q_q <= '0;
			r_q <= '0;
		end else if (cmd.idx_inc && multi) begin
			if (rsum >= {1'b0, div_l}) begin
				r_q <= 8'(rsum - {1'b0, div_l});
				q_q <= q_q + dq_q + 15'd1;
			end else begin
				r_q <= rsum[7:0];
				q_q <= q_q + dq_q;
			end
		end
		if (cmd.div_start) begin
			dq_q  <= diff_mag[14:0];
			rem_q <= '0;
		end else if (cmd.div_step) begin
			if (div_t >= {1'b0, div_l}) begin
				rem_q <= 8'(div_t - {1'b0, div_l});
				dq_q  <= {dq_q[13:0], 1'b1};
			end else begin
				rem_q <= div_t[7:0];
				dq_q  <= {dq_q[13:0], 1'b0};
			end
		end
		if (cmd.cor_load) begin
			d_q <= ram_rdata;
			x_q <= $signed({4'b0, xm, 16'b0});
			y_q <= $signed({{5{ym[26]}}, ym, 16'b0});
			z_q <= '0;
		end else if (cmd.cor_step) begin
			if (!y_q[47]) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + $signed({4'b0, atan_lut(step_q)});
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - $signed({4'b0, atan_lut(step_q)});
			end
		end
		if (cmd.ang_calc) cand_bin_q <= bin;
		if (cmd.pend_load) begin
			pend_bin_q <= cand_bin_q;
			pend_d_q   <= d_q;
		end
	end

	// output register
	logic over, mism;
	assign over = {1'b0, lsn_q} > 9'(MAX_SAMPLES);
	assign mism = cs_q != rxcs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.push_pend || cmd.push_final) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push_pend) begin
			status      <= ST_OK;
			has_sample  <= 1'b1;
			angle_bin   <= pend_bin_q;
			distance_mm <= pend_d_q;
			last        <= 1'b0;
		end else if (cmd.push_final) begin
			last <= 1'b1;
			if (over || mism || !have_pend_q) begin
				status      <= over ? ST_OVER : (mism ? ST_CSUM : ST_OK);
				has_sample  <= 1'b0;
				angle_bin   <= '0;
				distance_mm <= '0;
			end else begin
				status      <= ST_OK;
				has_sample  <= 1'b1;
				angle_bin   <= pend_bin_q;
				distance_mm <= pend_d_q;
			end
		end
	end

	assign sts.fin       = fin_q;
	assign sts.abort     = over || mism;
	assign sts.idx_done  = i_q == lsn_q;
	assign sts.dzero     = ram_rdata == '0;
	assign sts.div_done  = step_q == DIV_STEPS;
	assign sts.cor_done  = step_q == CORDIC_STEPS;
	assign sts.have_pend = have_pend_q;
	assign sts.out_free  = !out_valid || out_ready;

endmodule

// ----- src/lpfp_ctrl.sv -----
// ----------------------------------------------------------------------------
// lpfp_ctrl
// Sequencer: byte intake, end-of-packet decision and per-sample emission.
// ----------------------------------------------------------------------------
module lpfp_ctrl
	import lpfp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  lpfp_sts_t sts,
	output lpfp_cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE, S_BYTE, S_CHECK, S_DIV, S_NEXT, S_RDWAIT, S_COR, S_ANG, S_STORE, S_FINAL
	} state_t;

	state_t state_q, state_d;

	assign in_ready = state_q == S_IDLE;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.byte_en = 1'b1;
					state_d     = S_BYTE;
				end
			end
			S_BYTE: state_d = sts.fin ? S_CHECK : S_IDLE;
			S_CHECK: begin
				cmd.pend_clr = 1'b1;
				if (sts.abort) begin
					state_d = S_FINAL;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = S_DIV;
				end
			end
			S_DIV: begin
				if (sts.div_done) state_d = S_NEXT;
				else cmd.div_step = 1'b1;
			end
			S_NEXT: begin
				if (sts.idx_done) begin
					state_d = S_FINAL;
				end else begin
					cmd.rd_en = 1'b1;
					state_d   = S_RDWAIT;
				end
			end
			S_RDWAIT: begin
				if (sts.dzero) begin
					cmd.idx_inc = 1'b1;
					state_d     = S_NEXT;
				end else begin
					cmd.cor_load = 1'b1;
					state_d      = S_COR;
				end
			end
			S_COR: begin
				if (sts.cor_done) state_d = S_ANG;
				else cmd.cor_step = 1'b1;
			end
			S_ANG: begin
				cmd.ang_calc = 1'b1;
				state_d      = S_STORE;
			end
			S_STORE: begin
				// hold the newest result back until we know whether it is the last
				if (!sts.have_pend || sts.out_free) begin
					cmd.push_pend = sts.have_pend;
					cmd.pend_load = 1'b1;
					cmd.idx_inc   = 1'b1;
					state_d       = S_NEXT;
				end
			end
			S_FINAL: begin
				if (sts.out_free) begin
					cmd.push_final = 1'b1;
					state_d        = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- src/lidar_packet_framer_parser.sv -----
// ----------------------------------------------------------------------------
// lidar_packet_framer_parser
// Frames lidar scan packets from a byte stream, checks them and emits
// per-sample angle bin and distance updates.
//
// Channel   Dir  Handshake             Payload
// input     in   in_valid/in_ready     rx_byte
// output    out  out_valid/out_ready   status, has_sample, angle_bin,
//                                      distance_mm, last
//
// A byte passes through the sequencer's idle and byte states; non-final bytes
// give no output. At a packet's last byte: a check and an interpolation divide,
// then per stored sample a RAM read plus, when nonzero, CORDIC rotation, angle
// calculation and a store. Results leave through an output register; a stalled
// output holds the sequencer, and input is taken only between packets' work.
// Reset is asynchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module lidar_packet_framer_parser
	import lpfp_pkg::*;
#(
	parameter int MAX_SAMPLES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic        has_sample,
	output logic [8:0]  angle_bin,
	output logic [13:0] distance_mm,
	output logic        last
);

	lpfp_cmd_t cmd;
	lpfp_sts_t sts;

	lpfp_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	lpfp_datapath #(
		.MAX_SAMPLES(MAX_SAMPLES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.rx_byte    (rx_byte),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.status     (status),
		.has_sample (has_sample),
		.angle_bin  (angle_bin),
		.distance_mm(distance_mm),
		.last       (last)
	);

endmodule
